@@ sv/hrlp_pkg.sv @@
`timescale 1ns / 1ps

package hrlp_pkg;

  // characters the parser cares about
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // keyword lengths
  localparam int unsigned GET_LEN = 3;
  localparam int unsigned VER_LEN = 8;
  localparam int unsigned PRE_LEN = 7;

  // keywords, first character at index 0, upper case
  localparam logic [7:0] KW_GET [GET_LEN] = '{"G", "E", "T"};
  localparam logic [7:0] KW_VER [VER_LEN] = '{"H", "T", "T", "P", "/", "1", ".", "1"};
  localparam logic [7:0] KW_PRE [PRE_LEN] = '{"H", "T", "T", "P", ":", "/", "/"};

  // result status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // input op codes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       line_end;
  } out_item_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic               restart;
    logic               cr;
    logic               lf;
    logic               blank;
    logic               slash;
    logic [GET_LEN-1:0] get_hit;
    logic [VER_LEN-1:0] ver_hit;
    logic [PRE_LEN-1:0] pre_hit;
  } tok_t;

  // request line field being parsed
  typedef enum logic [4:0] {
    PH_METHOD = 5'b00001,
    PH_GAP1   = 5'b00010,
    PH_URL    = 5'b00100,
    PH_GAP2   = 5'b01000,
    PH_VER    = 5'b10000
  } phase_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= "a" && c <= "z") begin
      u = c - 8'd32;
    end
    return u;
  endfunction

endpackage

@@ sv/hrlp_front.sv @@
`timescale 1ns / 1ps

module hrlp_front (
  input  logic              push,
  input  hrlp_pkg::in_item_t in_item,
  output logic              full,
  input  logic              q_full,
  output logic              q_push,
  output hrlp_pkg::tok_t    q_tok
);

  logic [7:0] up;

  // queue backpressure goes straight to the source
  assign full   = q_full;
  assign q_push = push && !q_full;
  assign up     = hrlp_pkg::to_upper(in_item.data_byte);

  // byte classes and per-position keyword hits
  always_comb begin
    q_tok.restart = (in_item.op == hrlp_pkg::OP_RESTART);
    q_tok.cr      = (in_item.data_byte == hrlp_pkg::CH_CR);
    q_tok.lf      = (in_item.data_byte == hrlp_pkg::CH_LF);
    q_tok.blank   = (in_item.data_byte == hrlp_pkg::CH_SP) ||
                    (in_item.data_byte == hrlp_pkg::CH_TAB);
    q_tok.slash   = (in_item.data_byte == hrlp_pkg::CH_SLASH);
    for (int i = 0; i < hrlp_pkg::GET_LEN; i++) begin
      q_tok.get_hit[i] = (up == hrlp_pkg::KW_GET[i]);
    end
    for (int i = 0; i < hrlp_pkg::VER_LEN; i++) begin
      q_tok.ver_hit[i] = (up == hrlp_pkg::KW_VER[i]);
    end
    for (int i = 0; i < hrlp_pkg::PRE_LEN; i++) begin
      q_tok.pre_hit[i] = (up == hrlp_pkg::KW_PRE[i]);
    end
  end

endmodule

@@ sv/hrlp_fifo.sv @@
`timescale 1ns / 1ps

module hrlp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  hrlp_pkg::tok_t wr_tok,
  output logic           q_full,
  input  logic           rd_en,
  output logic           q_empty,
  output hrlp_pkg::tok_t rd_tok
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hrlp_pkg::tok_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_wr, do_rd;

  assign q_full  = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_tok  = mem_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_tok;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not rise on write");
`endif

endmodule

@@ sv/hrlp_back.sv @@
`timescale 1ns / 1ps

module hrlp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  hrlp_pkg::tok_t      q_tok,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output hrlp_pkg::out_item_t out_item
);

  logic                section_r, section_nxt;
  hrlp_pkg::phase_t    phase_r, phase_nxt;
  logic                prev_cr_r, prev_cr_nxt;
  logic [3:0]          kw_pos_r, kw_pos_nxt;
  logic                kw_mis_r, kw_mis_nxt;
  logic [2:0]          pre_pos_r, pre_pos_nxt;
  logic                pre_fail_r, pre_fail_nxt;
  logic                starts_slash_r, starts_slash_nxt;
  logic                slash_after_r, slash_after_nxt;
  logic                rl_err_r, rl_err_nxt;
  logic                hdr_empty_r, hdr_empty_nxt;
  logic [1:0]          outcome_r, outcome_nxt;
  logic                out_vld_r, out_vld_nxt;
  hrlp_pkg::out_item_t out_r, out_nxt;

  logic       take;
  logic       line_end;
  logic       line_ok;
  logic       url_ok;
  logic [2:0] url_pos;
  logic       url_fail;
  logic       url_slash;

  // take a token when the result register is free or drains this cycle
  assign take     = !q_empty && (!out_vld_r || pop);
  assign q_pop    = take;
  assign empty    = !out_vld_r;
  assign out_item = out_r;

  // url prefix tracking for the current byte
  always_comb begin
    url_pos   = pre_pos_r;
    url_fail  = pre_fail_r;
    url_slash = slash_after_r;
    if (pre_pos_r == 3'(hrlp_pkg::PRE_LEN)) begin
      if (q_tok.slash) begin
        url_slash = 1'b1;
      end
    end else if (!pre_fail_r) begin
      if (q_tok.pre_hit[pre_pos_r]) begin
        url_pos = pre_pos_r + 3'd1;
      end else begin
        url_fail = 1'b1;
      end
    end
  end

  // request line check at its closing lf
  assign url_ok  = (pre_pos_r == 3'(hrlp_pkg::PRE_LEN)) ? slash_after_r : starts_slash_r;
  assign line_ok = (phase_r == hrlp_pkg::PH_VER) && (kw_pos_r == 4'(hrlp_pkg::VER_LEN)) &&
                   !kw_mis_r && !rl_err_r && url_ok;

  // parser update
  always_comb begin
    section_nxt      = section_r;
    phase_nxt        = phase_r;
    prev_cr_nxt      = prev_cr_r;
    kw_pos_nxt       = kw_pos_r;
    kw_mis_nxt       = kw_mis_r;
    pre_pos_nxt      = pre_pos_r;
    pre_fail_nxt     = pre_fail_r;
    starts_slash_nxt = starts_slash_r;
    slash_after_nxt  = slash_after_r;
    rl_err_nxt       = rl_err_r;
    hdr_empty_nxt    = hdr_empty_r;
    outcome_nxt      = outcome_r;
    line_end         = 1'b0;
    if (take && q_tok.restart) begin
      section_nxt      = 1'b0;
      phase_nxt        = hrlp_pkg::PH_METHOD;
      prev_cr_nxt      = 1'b0;
      kw_pos_nxt       = '0;
      kw_mis_nxt       = 1'b0;
      pre_pos_nxt      = '0;
      pre_fail_nxt     = 1'b0;
      starts_slash_nxt = 1'b0;
      slash_after_nxt  = 1'b0;
      rl_err_nxt       = 1'b0;
      hdr_empty_nxt    = 1'b1;
      outcome_nxt      = hrlp_pkg::ST_RUN;
    end else if (take && outcome_r == hrlp_pkg::ST_RUN) begin
      if (prev_cr_r) begin
        prev_cr_nxt = 1'b0;
        if (!q_tok.lf) begin
          outcome_nxt = hrlp_pkg::ST_BAD;
        end else begin
          line_end = 1'b1;
          if (!section_r) begin
            if (line_ok) begin
              section_nxt   = 1'b1;
              hdr_empty_nxt = 1'b1;
            end else begin
              outcome_nxt = hrlp_pkg::ST_BAD;
            end
          end else if (hdr_empty_r) begin
            outcome_nxt = hrlp_pkg::ST_DONE;
          end else begin
            hdr_empty_nxt = 1'b1;
          end
        end
      end else if (q_tok.cr) begin
        prev_cr_nxt = 1'b1;
      end else if (q_tok.lf) begin
        outcome_nxt = hrlp_pkg::ST_BAD;
      end else if (!section_r) begin
        case (phase_r)
          hrlp_pkg::PH_METHOD: begin
            if (q_tok.blank) begin
              if (kw_mis_r || kw_pos_r != 4'(hrlp_pkg::GET_LEN)) begin
                rl_err_nxt = 1'b1;
              end
              phase_nxt = hrlp_pkg::PH_GAP1;
            end else if (kw_pos_r < 4'(hrlp_pkg::GET_LEN) && q_tok.get_hit[kw_pos_r[1:0]]) begin
              kw_pos_nxt = kw_pos_r + 4'd1;
            end else begin
              kw_mis_nxt = 1'b1;
            end
          end
          hrlp_pkg::PH_GAP1: begin
            if (!q_tok.blank) begin
              phase_nxt        = hrlp_pkg::PH_URL;
              starts_slash_nxt = q_tok.slash;
              pre_pos_nxt      = url_pos;
              pre_fail_nxt     = url_fail;
              slash_after_nxt  = url_slash;
            end
          end
          hrlp_pkg::PH_URL: begin
            if (q_tok.blank) begin
              phase_nxt = hrlp_pkg::PH_GAP2;
            end else begin
              pre_pos_nxt     = url_pos;
              pre_fail_nxt    = url_fail;
              slash_after_nxt = url_slash;
            end
          end
          hrlp_pkg::PH_GAP2: begin
            if (!q_tok.blank) begin
              phase_nxt = hrlp_pkg::PH_VER;
              if (q_tok.ver_hit[0]) begin
                kw_pos_nxt = 4'd1;
                kw_mis_nxt = 1'b0;
              end else begin
                kw_pos_nxt = 4'd0;
                kw_mis_nxt = 1'b1;
              end
            end
          end
          hrlp_pkg::PH_VER: begin
            if (q_tok.blank) begin
              kw_mis_nxt = 1'b1;
            end else if (kw_pos_r < 4'(hrlp_pkg::VER_LEN) && q_tok.ver_hit[kw_pos_r[2:0]]) begin
              kw_pos_nxt = kw_pos_r + 4'd1;
            end else begin
              kw_mis_nxt = 1'b1;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end else begin
        hdr_empty_nxt = 1'b0;
      end
    end
  end

  // result register
  always_comb begin
    out_nxt.status   = outcome_nxt;
    out_nxt.line_end = line_end;
    if (take) begin
      out_vld_nxt = 1'b1;
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r      <= 1'b0;
      phase_r        <= hrlp_pkg::PH_METHOD;
      prev_cr_r      <= 1'b0;
      kw_pos_r       <= '0;
      kw_mis_r       <= 1'b0;
      pre_pos_r      <= '0;
      pre_fail_r     <= 1'b0;
      starts_slash_r <= 1'b0;
      slash_after_r  <= 1'b0;
      rl_err_r       <= 1'b0;
      hdr_empty_r    <= 1'b1;
      outcome_r      <= hrlp_pkg::ST_RUN;
      out_vld_r      <= 1'b0;
    end else begin
      section_r      <= section_nxt;
      phase_r        <= phase_nxt;
      prev_cr_r      <= prev_cr_nxt;
      kw_pos_r       <= kw_pos_nxt;
      kw_mis_r       <= kw_mis_nxt;
      pre_pos_r      <= pre_pos_nxt;
      pre_fail_r     <= pre_fail_nxt;
      starts_slash_r <= starts_slash_nxt;
      slash_after_r  <= slash_after_nxt;
      rl_err_r       <= rl_err_nxt;
      hdr_empty_r    <= hdr_empty_nxt;
      outcome_r      <= outcome_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_outcome_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !q_tok.restart && outcome_r != hrlp_pkg::ST_RUN) |=>
      (outcome_r == $past(outcome_r)))
    else $error("outcome changed without restart");

  a_line_end_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (take && line_end) |-> (prev_cr_r && q_tok.lf))
    else $error("line end without cr lf");

  a_headers_after_ver: assert property (@(posedge clk) disable iff (!rst_n)
    section_r |-> (phase_r == hrlp_pkg::PH_VER))
    else $error("header section entered before version field");
`endif

endmodule

@@ sv/http_request_line_parser.sv @@
`timescale 1ns / 1ps

// channel   ports                      direction  item
// input     push, full, in_item        in         op, data_byte
// result    empty, pop, out_item       out        status, line_end
//
// one byte per cycle sustained while results are popped; a byte is written to the queue, then
// the parser stage takes it from the queue and fills the result register
// the parser state and result register form the only serial loop, one byte a cycle while results are popped
// reset is synchronous, active low, and leaves the parser waiting for a method
// full rises only when QUEUE_DEPTH bytes wait behind a result that is not popped

module http_request_line_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  hrlp_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output hrlp_pkg::out_item_t out_item
);

  logic           q_full;
  logic           q_push;
  logic           q_empty;
  logic           q_pop;
  hrlp_pkg::tok_t wr_tok;
  hrlp_pkg::tok_t rd_tok;

  // classify incoming bytes
  hrlp_front u_front (
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_tok   (wr_tok)
  );

  // decoupling queue
  hrlp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_tok  (wr_tok),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_tok  (rd_tok)
  );

  // parser state and result register
  hrlp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_tok    (rd_tok),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
